// ----- rtl/core/stat_pkg.sv -----
// Package for the sensor threshold alarm table.
// Holds item codes, the shared item and control structs, and the reading and
// comparison helpers used by the job cells. No dependencies.
package stat_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAVE   = 2'd1,
        OP_DELETE = 2'd2,
        OP_SENSOR = 2'd3
    } t_op;

    // Sensor select codes; codes above SNS_RSSI select no sensor
    localparam logic [2:0] SNS_LIGHT = 3'd0;
    localparam logic [2:0] SNS_TEMP  = 3'd1;
    localparam logic [2:0] SNS_POWER = 3'd2;
    localparam logic [2:0] SNS_UPTIME = 3'd3;
    localparam logic [2:0] SNS_RSSI  = 3'd4;
    localparam int         SENSORS   = 5;

    // Compare codes; codes above CMP_EQ always hold
    localparam logic [2:0] CMP_GT = 3'd0;
    localparam logic [2:0] CMP_GE = 3'd1;
    localparam logic [2:0] CMP_LT = 3'd2;
    localparam logic [2:0] CMP_LE = 3'd3;
    localparam logic [2:0] CMP_EQ = 3'd4;

    localparam logic [15:0] CHECK_STEP_RESET = 16'd128;

    typedef logic [SENSORS-1:0][31:0] t_readings;

    // One accepted input item, held for the whole walk down the cell row
    typedef struct packed {
        t_op         op;
        logic [3:0]  slot;
        logic [14:0] job_id;
        logic        is_alert;
        logic [2:0]  sensor_sel;
        logic [2:0]  cmp_op;
        logic [31:0] value;
        logic [15:0] interval_s;
        logic [31:0] win_start;
        logic [31:0] time_to;
        logic [31:0] clock_now;
    } t_item;

    // Shared control seen by every cell
    typedef struct packed {
        t_item       item;
        logic [15:0] step;
        logic        adv;
    } t_ctrl;

    // Reading for a sensor code; unknown codes report not present
    function automatic logic [32:0] get_reading(input t_readings rd, input logic [2:0] sel);
        logic [32:0] res;
        case (sel)
            SNS_LIGHT:  res = {1'b1, rd[0]};
            SNS_TEMP:   res = {1'b1, rd[1]};
            SNS_POWER:  res = {1'b1, rd[2]};
            SNS_UPTIME: res = {1'b1, rd[3]};
            SNS_RSSI:   res = {1'b1, rd[4]};
            default:    res = '0;
        endcase
        return res;
    endfunction

    // Signed threshold test
    function automatic logic holds(input logic signed [31:0] rdg, input logic [2:0] cmp,
                                   input logic signed [31:0] thr);
        logic res;
        case (cmp)
            CMP_GT:  res = rdg > thr;
            CMP_GE:  res = rdg >= thr;
            CMP_LT:  res = rdg < thr;
            CMP_LE:  res = rdg <= thr;
            CMP_EQ:  res = rdg == thr;
            default: res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/sensor_threshold_alarm_table.sv -----
// Alarm table: a token walks a row of job cells, one cell per cycle while
// the row is not held by a stalled tick result. Tick items give a result
// once the walk is done; save and delete items give none. The next item is
// taken after the walk. Sensor updates give no result and do not block the
// input. Synchronous active-low reset empties all slots, zeroes elapsed
// times and readings, and sets the check step to 128.
module sensor_threshold_alarm_table
    import stat_pkg::*;
#(
    parameter int JOBS             = 16,
    parameter int TICKS_PER_SECOND = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_slot,
    input  logic [14:0] i_job_id,
    input  logic        i_is_alert,
    input  logic [2:0]  i_sensor_sel,
    input  logic [2:0]  i_cmp_op,
    input  logic signed [31:0] i_value,
    input  logic [15:0] i_interval_s,
    input  logic signed [31:0] i_win_start,
    input  logic signed [31:0] i_time_to,
    input  logic signed [31:0] i_clock_now,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_fired_mask
);

    localparam int OUT_W = 16;

    logic [15:0]     r_check_step;
    t_readings       r_readings;
    t_item           r_item;
    logic            r_launch;
    logic            r_busy;
    logic            r_out_valid;
    logic [OUT_W-1:0] r_out_mask, n_out_mask;

    logic            in_xfer;
    logic            last_tok;
    logic            adv;
    t_ctrl           ctrl;
    logic [JOBS:0]   w_tok;
    logic [JOBS:0][JOBS-1:0] w_mask;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign last_tok = w_tok[JOBS];
    // hold the row when a finished tick cannot enter the output register
    assign adv = !(last_tok && r_item.op == OP_TICK && r_out_valid && i_out_stall);

    assign ctrl.item = r_item;
    assign ctrl.step = r_check_step;
    assign ctrl.adv  = adv;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_step <= CHECK_STEP_RESET;
        end else if (i_cfg_we) begin
            r_check_step <= i_cfg_wdata;
        end
    end

    // sensor reading bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_readings <= '0;
        end else if (in_xfer && t_op'(i_op) == OP_SENSOR) begin
            case (i_sensor_sel)
                SNS_LIGHT:  r_readings[0] <= i_value;
                SNS_TEMP:   r_readings[1] <= i_value;
                SNS_POWER:  r_readings[2] <= i_value;
                SNS_UPTIME: r_readings[3] <= i_value;
                SNS_RSSI:   r_readings[4] <= i_value;
                default: begin
                end
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.op         <= t_op'(i_op);
            r_item.slot       <= i_slot;
            r_item.job_id     <= i_job_id;
            r_item.is_alert   <= i_is_alert;
            r_item.sensor_sel <= i_sensor_sel;
            r_item.cmp_op     <= i_cmp_op;
            r_item.value      <= i_value;
            r_item.interval_s <= i_interval_s;
            r_item.win_start  <= i_win_start;
            r_item.time_to    <= i_time_to;
            r_item.clock_now  <= i_clock_now;
        end
    end

    // token launch and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= 1'b0;
            r_busy   <= 1'b0;
        end else begin
            r_launch <= in_xfer && t_op'(i_op) != OP_SENSOR;
            if (in_xfer && t_op'(i_op) != OP_SENSOR) begin
                r_busy <= 1'b1;
            end else if (last_tok && adv) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_in_stall = r_busy;

    // row of job cells
    assign w_tok[0]  = r_launch;
    assign w_mask[0] = '0;

    for (genvar g = 0; g < JOBS; g++) begin : g_cell
        stat_cell #(
            .IDX  (g),
            .JOBS (JOBS),
            .TPS  (TICKS_PER_SECOND)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_readings (r_readings),
            .i_tok      (w_tok[g]),
            .i_mask     (w_mask[g]),
            .o_tok      (w_tok[g+1]),
            .o_mask     (w_mask[g+1])
        );
    end

    // slots 0 to 15 of the finished mask
    for (genvar b = 0; b < OUT_W; b++) begin : g_out
        if (b < JOBS) begin : g_used
            assign n_out_mask[b] = w_mask[JOBS][b];
        end else begin : g_pad
            assign n_out_mask[b] = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (last_tok && adv && r_item.op == OP_TICK) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_tok && adv && r_item.op == OP_TICK) begin
            r_out_mask <= n_out_mask;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_fired_mask = r_out_mask;

endmodule

// ----- rtl/core/stat_cell.sv -----
// One job cell of the alarm table row: stores one job and acts on the item
// when the token reaches it, then hands token and fired mask on.
// Depends on stat_pkg.
module stat_cell
    import stat_pkg::*;
#(
    parameter int IDX  = 0,
    parameter int JOBS = 16,
    parameter int TPS  = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl            i_ctrl,
    input  t_readings        i_readings,
    input  logic             i_tok,
    input  logic [JOBS-1:0]  i_mask,
    output logic             o_tok,
    output logic [JOBS-1:0]  o_mask
);

    // job record
    logic               r_valid, n_valid;
    logic [14:0]        r_id, n_id;
    logic               r_alert, n_alert;
    logic [2:0]         r_sensor, n_sensor;
    logic [2:0]         r_cmp, n_cmp;
    logic signed [31:0] r_thr, n_thr;
    logic [31:0]        r_limit, n_limit;
    logic signed [31:0] r_from, n_from;
    logic signed [31:0] r_to, n_to;
    logic [31:0]        r_elapsed, n_elapsed;
    // chain stage
    logic               r_tok;
    logic [JOBS-1:0]    r_mask, n_mask;

    logic               act;
    logic               in_window;
    logic [32:0]        rdg;
    logic               cond;
    logic [32:0]        sum;
    logic [31:0]        grown;
    logic               fire;

    assign act = i_tok && i_ctrl.adv;

    // tick evaluation
    always_comb begin
        in_window = !(r_from > $signed(i_ctrl.item.clock_now)) &&
                    !(r_to < $signed(i_ctrl.item.clock_now));
        rdg       = get_reading(i_readings, r_sensor);
        cond      = rdg[32] && holds($signed(rdg[31:0]), r_cmp, r_thr);
        sum       = {1'b0, r_elapsed} + {17'b0, i_ctrl.step};
        grown     = sum[32] ? '1 : sum[31:0];
    end

    // next state of the job record
    always_comb begin
        n_valid   = r_valid;
        n_id      = r_id;
        n_alert   = r_alert;
        n_sensor  = r_sensor;
        n_cmp     = r_cmp;
        n_thr     = r_thr;
        n_limit   = r_limit;
        n_from    = r_from;
        n_to      = r_to;
        n_elapsed = r_elapsed;
        fire      = 1'b0;
        if (act) begin
            case (i_ctrl.item.op)
                OP_SAVE: begin
                    if (int'(i_ctrl.item.slot) == IDX) begin
                        n_valid   = 1'b1;
                        n_id      = i_ctrl.item.job_id;
                        n_alert   = i_ctrl.item.is_alert;
                        n_sensor  = i_ctrl.item.sensor_sel;
                        n_cmp     = i_ctrl.item.cmp_op;
                        n_thr     = $signed(i_ctrl.item.value);
                        n_limit   = 32'(i_ctrl.item.interval_s) * 32'(TPS);
                        n_from    = $signed(i_ctrl.item.win_start);
                        n_to      = $signed(i_ctrl.item.time_to);
                        n_elapsed = '0;
                    end
                end
                OP_DELETE: begin
                    if (r_valid && r_id == i_ctrl.item.job_id) begin
                        n_valid = 1'b0;
                    end
                end
                OP_TICK: begin
                    if (r_valid && r_alert && in_window) begin
                        n_elapsed = cond ? grown : '0;
                        if (n_elapsed >= r_limit) begin
                            fire      = 1'b1;
                            n_elapsed = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_mask      = i_mask;
        n_mask[IDX] = i_mask[IDX] | fire;
    end

    // record storage; job fields other than valid and elapsed need no reset
    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_alert  <= n_alert;
        r_sensor <= n_sensor;
        r_cmp    <= n_cmp;
        r_thr    <= n_thr;
        r_limit  <= n_limit;
        r_from   <= n_from;
        r_to     <= n_to;
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_elapsed <= '0;
        end else begin
            r_valid   <= n_valid;
            r_elapsed <= n_elapsed;
        end
    end

    // hand token and mask to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_mask <= '0;
        end else if (i_ctrl.adv) begin
            r_tok  <= i_tok;
            r_mask <= n_mask;
        end
    end

    assign o_tok  = r_tok;
    assign o_mask = r_mask;

endmodule

// ----- rtl/core/stat_checker.sv -----
// Port-level checks for the alarm table, bound to the top level.
// Depends on stat_pkg and sensor_threshold_alarm_table.
module stat_checker
    import stat_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_op,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_fired_mask
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its mask
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_fired_mask))
        else $error("mask changed while stalled");

    // tick, save and delete occupy the cell row
    a_busy_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op != OP_SENSOR |=> o_in_stall)
        else $error("next item taken while row busy");

    // sensor updates leave the input free
    a_sensor_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op == OP_SENSOR |=> !o_in_stall)
        else $error("sensor update blocked the input");

endmodule

bind sensor_threshold_alarm_table stat_checker u_stat_checker (.*);
